@@ design/tlv_token_stream_framer_top_assert.svh @@
// Assertion macros for the token stream framer checker.
// Depends on clk_i and rst_ni being visible where the macros are used.
`ifndef TLV_TOKEN_STREAM_FRAMER_TOP_ASSERT_SVH
`define TLV_TOKEN_STREAM_FRAMER_TOP_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define TLVF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define TLVF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/tlvf_pkg.sv @@
// Shared types, codes and key length table for the token stream framer.
// No dependencies.
package tlvf_pkg;

  localparam int unsigned NETWORK_NAME_LEN_DEF  = 2;
  localparam int unsigned STATION_NAME_LEN_DEF  = 5;
  localparam int unsigned LOCATION_NAME_LEN_DEF = 2;
  localparam int unsigned CHANNEL_NAME_LEN_DEF  = 3;

  localparam int unsigned PW_PART = 7;
  localparam logic [15:0] DSS_LEN = 16'(3 * PW_PART + 4 + 4 + 1 + 1 + 2 + 2);

  localparam logic [7:0] LAST_FIXED_KEY = 8'd9;
  localparam logic [15:0] POS_MAX       = 16'hFFFF;
  localparam logic [15:0] COUNT_MAX     = 16'hFFFF;

  typedef enum logic [1:0] {
    ERR_NONE         = 2'd0,
    ERR_UNKNOWN_KEY  = 2'd1,
    ERR_TRUNCATED    = 2'd2,
    ERR_SHORT_LENGTH = 2'd3
  } err_e;

  typedef enum logic [3:0] {
    PH_KEY   = 4'b0001,
    PH_LEN_A = 4'b0010,
    PH_LEN_B = 4'b0100,
    PH_BODY  = 4'b1000
  } phase_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       block_last;
  } word_t;

  typedef struct packed {
    logic [7:0]  token_key;
    logic [15:0] body_index;
    logic        is_key;
    logic        token_end;
    logic        variable_length;
    logic [15:0] token_length;
    err_e        error_code;
    logic [15:0] token_count;
  } result_t;

  // Body length of a fixed key 1..9; len2, len7, len8 follow the name lengths.
  function automatic logic [15:0] fixed_len(logic [3:0] k, logic [15:0] len2,
                                            logic [15:0] len7, logic [15:0] len8);
    logic [15:0] r;
    unique case (k)
      4'd1:                r = 16'd1;
      4'd2:                r = len2;
      4'd3, 4'd5, 4'd9:    r = 16'd2;
      4'd4:                r = DSS_LEN;
      4'd6:                r = 16'd16;
      4'd7:                r = len7;
      4'd8:                r = len8;
      default:             r = 16'd0;
    endcase
    return r;
  endfunction

endpackage

@@ design/tlvf_skid.sv @@
// Two-entry input buffer with a registered stall for the token stream framer.
// Depends on tlvf_pkg.
module tlvf_skid (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  tlvf_pkg::word_t in_word_i,
  output logic          in_stall_o,
  output logic          head_valid_o,
  output tlvf_pkg::word_t head_word_o,
  input  logic          pop_i
);

  logic            head_valid_q, head_valid_d;
  logic            spare_valid_q, spare_valid_d;
  tlvf_pkg::word_t head_q, head_d;
  tlvf_pkg::word_t spare_q, spare_d;
  logic            accept;

  assign in_stall_o   = spare_valid_q;
  assign accept       = in_valid_i && !spare_valid_q;
  assign head_valid_o = head_valid_q;
  assign head_word_o  = head_q;

  always_comb begin
    head_valid_d  = head_valid_q;
    spare_valid_d = spare_valid_q;
    head_d        = head_q;
    spare_d       = spare_q;
    if (spare_valid_q) begin
      // no accept possible; refill head from the spare on pop
      if (pop_i) begin
        head_d        = spare_q;
        spare_valid_d = 1'b0;
      end
    end else if (accept) begin
      if (head_valid_q && !pop_i) begin
        spare_d       = in_word_i;
        spare_valid_d = 1'b1;
      end else begin
        head_d       = in_word_i;
        head_valid_d = 1'b1;
      end
    end else if (pop_i) begin
      head_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_valid_q  <= 1'b0;
      spare_valid_q <= 1'b0;
    end else begin
      head_valid_q  <= head_valid_d;
      spare_valid_q <= spare_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q  <= head_d;
    spare_q <= spare_d;
  end

endmodule

@@ design/tlvf_core.sv @@
// Token decode, framing state and result register of the token stream framer.
// Depends on tlvf_pkg.
module tlvf_core #(
  parameter int unsigned NETWORK_NAME_LEN  = tlvf_pkg::NETWORK_NAME_LEN_DEF,
  parameter int unsigned STATION_NAME_LEN  = tlvf_pkg::STATION_NAME_LEN_DEF,
  parameter int unsigned LOCATION_NAME_LEN = tlvf_pkg::LOCATION_NAME_LEN_DEF,
  parameter int unsigned CHANNEL_NAME_LEN  = tlvf_pkg::CHANNEL_NAME_LEN_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              word_valid_i,
  input  tlvf_pkg::word_t   word_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output tlvf_pkg::result_t result_o
);

  localparam logic [15:0] Len2 = 16'(NETWORK_NAME_LEN + STATION_NAME_LEN);
  localparam logic [15:0] Len7 = 16'(2 * (LOCATION_NAME_LEN + CHANNEL_NAME_LEN));
  localparam logic [15:0] Len8 = 16'(LOCATION_NAME_LEN + CHANNEL_NAME_LEN + 3);

  tlvf_pkg::phase_e phase_q, phase_d;
  logic [7:0]  key_q, key_d;
  logic [15:0] left_q, left_d;
  logic [15:0] pos_q, pos_d;
  logic [7:0]  lenh_q, lenh_d;
  logic [15:0] blen_q, blen_d;
  logic [15:0] count_q, count_d;
  logic        out_valid_q;
  tlvf_pkg::result_t res_q, res_d;

  logic        fire;
  logic [7:0]  b;
  logic        is_key;
  logic        tok_end;
  tlvf_pkg::err_e err;
  logic        have_len;
  logic [15:0] len;
  logic [15:0] fs;
  logic [15:0] count_out;

  // Advance when the result register is free or being drained.
  assign fire        = word_valid_i && (!out_valid_q || !out_stall_i);
  assign pop_o       = fire;
  assign out_valid_o = out_valid_q;
  assign result_o    = res_q;
  assign b           = word_i.data_byte;

  always_comb begin
    phase_d   = phase_q;
    key_d     = key_q;
    left_d    = left_q;
    pos_d     = pos_q;
    lenh_d    = lenh_q;
    blen_d    = blen_q;
    is_key    = 1'b0;
    tok_end   = 1'b0;
    err       = tlvf_pkg::ERR_NONE;
    have_len  = 1'b0;
    len       = 16'd0;
    fs        = 16'd0;
    count_out = count_q;

    unique case (phase_q)
      tlvf_pkg::PH_KEY: begin
        key_d  = b;
        is_key = 1'b1;
        pos_d  = 16'd0;
        blen_d = 16'd0;
        lenh_d = 8'd0;
        left_d = 16'd0;
        if (b == 8'd0) begin
          tok_end = 1'b1;
        end else if (b[7]) begin
          phase_d = tlvf_pkg::PH_LEN_A;
        end else if (b <= tlvf_pkg::LAST_FIXED_KEY) begin
          blen_d  = tlvf_pkg::fixed_len(b[3:0], Len2, Len7, Len8);
          left_d  = blen_d;
          phase_d = tlvf_pkg::PH_BODY;
        end else begin
          err     = tlvf_pkg::ERR_UNKNOWN_KEY;
          tok_end = 1'b1;
        end
      end
      tlvf_pkg::PH_LEN_A: begin
        pos_d = 16'd1;
        if (key_q[6]) begin
          lenh_d  = b;
          phase_d = tlvf_pkg::PH_LEN_B;
        end else begin
          len      = {8'd0, b};
          fs       = 16'd1;
          have_len = 1'b1;
        end
      end
      tlvf_pkg::PH_LEN_B: begin
        pos_d    = 16'd2;
        len      = {lenh_q, b};
        fs       = 16'd2;
        have_len = 1'b1;
      end
      tlvf_pkg::PH_BODY: begin
        if (pos_q != tlvf_pkg::POS_MAX) begin
          pos_d = pos_q + 16'd1;
        end
        if (left_q <= 16'd1) begin
          left_d  = 16'd0;
          tok_end = 1'b1;
        end else begin
          left_d = left_q - 16'd1;
        end
      end
      default: begin
        phase_d = tlvf_pkg::PH_KEY;
      end
    endcase

    if (have_len) begin
      blen_d = len;
      if (len < fs) begin
        err     = tlvf_pkg::ERR_SHORT_LENGTH;
        tok_end = 1'b1;
      end else if (len == fs) begin
        tok_end = 1'b1;
      end else begin
        left_d  = len - fs;
        phase_d = tlvf_pkg::PH_BODY;
      end
    end

    if (tok_end) begin
      phase_d = tlvf_pkg::PH_KEY;
      if (err != tlvf_pkg::ERR_UNKNOWN_KEY && count_q != tlvf_pkg::COUNT_MAX) begin
        count_out = count_q + 16'd1;
      end
    end else if (word_i.block_last) begin
      err = tlvf_pkg::ERR_TRUNCATED;
    end

    res_d.token_key       = key_d;
    res_d.body_index      = pos_d;
    res_d.is_key          = is_key;
    res_d.token_end       = tok_end;
    res_d.variable_length = key_d[7];
    res_d.token_length    = blen_d;
    res_d.error_code      = err;
    res_d.token_count     = count_out;

    count_d = count_out;
    // Block end: restart framing and the token count.
    if (word_i.block_last) begin
      phase_d = tlvf_pkg::PH_KEY;
      count_d = 16'd0;
      left_d  = 16'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= tlvf_pkg::PH_KEY;
      key_q       <= 8'd0;
      left_q      <= 16'd0;
      pos_q       <= 16'd0;
      lenh_q      <= 8'd0;
      blen_q      <= 16'd0;
      count_q     <= 16'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        phase_q <= phase_d;
        key_q   <= key_d;
        left_q  <= left_d;
        pos_q   <= pos_d;
        lenh_q  <= lenh_d;
        blen_q  <= blen_d;
        count_q <= count_d;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res_d;
    end
  end

endmodule

@@ design/tlv_token_stream_framer_top.sv @@
// Top level of the type-length-value token stream framer.
// Depends on tlvf_pkg, tlvf_skid and tlvf_core.
//
// Usage:
//   Input channel: one block byte per word (data_byte_i, block_last_i) under
//   in_valid_i / in_stall_o. Output channel: one tagged result word per input
//   word under out_valid_o / out_stall_i. A word moves on a rising edge with
//   valid high and stall low.
//   Path: an accepted byte is registered in the input buffer, then its result
//   is registered in the result register, from which it leaves the block.
//   Throughput: one byte per cycle sustained while out_stall_i is low; the per-byte
//   decode and counter updates are combinational between the input buffer and the result register.
//   in_stall_o comes straight from a flop (the buffer's spare entry), so the
//   input side never sees a combinational path from out_stall_i.
//   Receiver stall: the result register holds its word, the input buffer
//   absorbs bytes until both its entries are full and then raises in_stall_o.
//   Reset: rst_ni low clears both buffers and the framing state; the block
//   then expects a key byte with a token count of zero.
//   Block end: block_last_i on a byte returns the framer to key expectation
//   and clears the token count for the next block.
module tlv_token_stream_framer_top #(
  parameter int unsigned NETWORK_NAME_LEN  = tlvf_pkg::NETWORK_NAME_LEN_DEF,
  parameter int unsigned STATION_NAME_LEN  = tlvf_pkg::STATION_NAME_LEN_DEF,
  parameter int unsigned LOCATION_NAME_LEN = tlvf_pkg::LOCATION_NAME_LEN_DEF,
  parameter int unsigned CHANNEL_NAME_LEN  = tlvf_pkg::CHANNEL_NAME_LEN_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        block_last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  token_key_o,
  output logic [15:0] body_index_o,
  output logic        is_key_o,
  output logic        token_end_o,
  output logic        variable_length_o,
  output logic [15:0] token_length_o,
  output logic [1:0]  error_code_o,
  output logic [15:0] token_count_o
);

  tlvf_pkg::word_t   in_word;
  tlvf_pkg::word_t   head_word;
  tlvf_pkg::result_t result;
  logic              head_valid;
  logic              pop;

  assign in_word.data_byte  = data_byte_i;
  assign in_word.block_last = block_last_i;

  // Input buffer: registered stall, holds up to two bytes.
  tlvf_skid u_skid (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_word_i    (in_word),
    .in_stall_o   (in_stall_o),
    .head_valid_o (head_valid),
    .head_word_o  (head_word),
    .pop_i        (pop)
  );

  // Decode and framing state; result register drives the output channel.
  tlvf_core #(
    .NETWORK_NAME_LEN  (NETWORK_NAME_LEN),
    .STATION_NAME_LEN  (STATION_NAME_LEN),
    .LOCATION_NAME_LEN (LOCATION_NAME_LEN),
    .CHANNEL_NAME_LEN  (CHANNEL_NAME_LEN)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .word_valid_i (head_valid),
    .word_i       (head_word),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .result_o     (result)
  );

  // Unpack the result word onto the field ports.
  assign token_key_o       = result.token_key;
  assign body_index_o      = result.body_index;
  assign is_key_o          = result.is_key;
  assign token_end_o       = result.token_end;
  assign variable_length_o = result.variable_length;
  assign token_length_o    = result.token_length;
  assign error_code_o      = result.error_code;
  assign token_count_o     = result.token_count;

endmodule

@@ design/tlvf_checker.sv @@
// Port-level checker for the token stream framer, bound to the top level.
// Depends on tlvf_pkg and tlv_token_stream_framer_top_assert.svh.
`include "tlv_token_stream_framer_top_assert.svh"

module tlvf_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic [7:0]  data_byte_i,
  input logic        block_last_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [7:0]  token_key_o,
  input logic [15:0] body_index_o,
  input logic        is_key_o,
  input logic        token_end_o,
  input logic        variable_length_o,
  input logic [15:0] token_length_o,
  input logic [1:0]  error_code_o,
  input logic [15:0] token_count_o
);

  `TLVF_ASSERT_IMP(a_key_at_zero, out_valid_o && is_key_o, body_index_o == 16'd0, "key byte off position zero")
  `TLVF_ASSERT_IMP(a_trunc_open, out_valid_o && (error_code_o == tlvf_pkg::ERR_TRUNCATED), !token_end_o, "truncation on a closing byte")
  `TLVF_ASSERT_IMP(a_unknown_key, out_valid_o && (error_code_o == tlvf_pkg::ERR_UNKNOWN_KEY), is_key_o && token_end_o, "unknown key not closed at its key byte")
  `TLVF_ASSERT_IMP(a_varlen_bit, out_valid_o, variable_length_o == token_key_o[7], "length flag disagrees with key")
  `TLVF_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(token_count_o), "stalled result changed")

endmodule

bind tlv_token_stream_framer_top tlvf_checker u_tlvf_checker (.*);
